// ----- design/scs_pkg.sv -----
`timescale 1ns / 1ps

package scs_pkg;

  // Sizing defaults and fixed field widths
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CREDIT_W        = 16;
  localparam int VAL_W           = 8;
  localparam int IDX_W           = 4;
  localparam int NUM_W           = 5;
  localparam int HALF_DIV        = 2;
  localparam logic [NUM_W-1:0] NUM_ENTRIES_RST = NUM_W'(16);

  // Item opcodes
  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_FLAGS   = 3'd1,
    OP_TICK    = 3'd2,
    OP_RELEASE = 3'd3,
    OP_DRAIN   = 3'd4
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RMW,
    ST_SCAN,
    ST_WIN,
    ST_DONE
  } state_e;

  // Credit unit operations
  typedef enum logic [1:0] {
    CU_ADD_SAT,
    CU_SUB_CLAMP,
    CU_SET
  } cu_mode_e;

  // One table entry as stored
  typedef struct packed {
    logic [CREDIT_W-1:0] credit;
    logic [VAL_W-1:0]    weight;
    logic [VAL_W-1:0]    threshold;
    logic                group;
    logic                alive;
    logic                stunned;
  } entry_t;

  // Credit unit results
  typedef struct packed {
    logic [CREDIT_W-1:0] value;
    logic                meets;
    logic                beats;
  } cu_res_t;

endpackage

// ----- design/scs_entry_mem.sv -----
`timescale 1ns / 1ps

module scs_entry_mem #(
  parameter int MAX_ENTRIES = scs_pkg::MAX_ENTRIES_DEF,
  localparam int IW = $clog2(MAX_ENTRIES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IW-1:0]   rd_addr_i,
  output scs_pkg::entry_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [IW-1:0]   wr_addr_i,
  input  scs_pkg::entry_t wr_data_i
);

  scs_pkg::entry_t       mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q;
  scs_pkg::entry_t       rdata_q;
  logic                  rvalid_q;

  // Entry storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Valid bits: an entry never written reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

// ----- design/scs_credit_unit.sv -----
`timescale 1ns / 1ps

module scs_credit_unit (
  input  scs_pkg::cu_mode_e                mode_i,
  input  logic [scs_pkg::CREDIT_W-1:0]     credit_i,
  input  logic [scs_pkg::CREDIT_W-1:0]     operand_i,
  input  logic [scs_pkg::VAL_W-1:0]        threshold_i,
  input  logic [scs_pkg::CREDIT_W-1:0]     best_i,
  output scs_pkg::cu_res_t                 res_o
);

  logic [scs_pkg::CREDIT_W:0]   sum;
  logic [scs_pkg::CREDIT_W-1:0] value;

  assign sum = {1'b0, credit_i} + {1'b0, operand_i};

  // Shared add / subtract / load of one credit value
  always_comb begin
    unique case (mode_i)
      scs_pkg::CU_ADD_SAT:   value = sum[scs_pkg::CREDIT_W] ? '1 : sum[scs_pkg::CREDIT_W-1:0];
      scs_pkg::CU_SUB_CLAMP: value = (credit_i > operand_i) ? credit_i - operand_i : '0;
      scs_pkg::CU_SET:       value = operand_i;
      default:               value = credit_i;
    endcase
  end

  // Threshold check and compare against the best so far
  assign res_o.value = value;
  assign res_o.meets = value >= scs_pkg::CREDIT_W'(threshold_i);
  assign res_o.beats = value > best_i;

endmodule

// ----- design/credit_threshold_scheduler.sv -----
// Credit threshold scheduler, one item at a time through a shared credit unit.
// Load, flags, drain and release pass through decode, read-modify-write and done;
// an item that changes nothing goes from decode to done; a tick scans the n
// active entries, takes a win step when it grants, then reaches done.
// The next item is taken the cycle after the result loads; a stalled result
// holds the sequencer. Reset (async, active low) empties table and grant.
`timescale 1ns / 1ps

module credit_threshold_scheduler #(
  parameter int MAX_ENTRIES = scs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [scs_pkg::NUM_W-1:0]     cfg_num_entries_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    op_i,
  input  logic [scs_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [scs_pkg::VAL_W-1:0]     weight_i,
  input  logic [scs_pkg::VAL_W-1:0]     threshold_i,
  input  logic                          group_i,
  input  logic                          alive_i,
  input  logic                          stunned_i,
  input  logic                          freeze_group1_i,
  input  logic                          release_skip_i,
  input  logic [scs_pkg::VAL_W-1:0]     drain_amount_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          granted_o,
  output logic [scs_pkg::IDX_W-1:0]     grant_index_o,
  output logic                          grant_group_o,
  output logic                          busy_res_o,
  output logic [scs_pkg::CREDIT_W-1:0]  winner_credit_o
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = IW + 1;

  scs_pkg::state_e state_q, state_d;

  // latched item
  logic [2:0]                   op_q;
  logic [scs_pkg::IDX_W-1:0]    idx_q;
  logic [scs_pkg::VAL_W-1:0]    weight_q, threshold_q, drain_q;
  logic                         group_q, alive_q, stunned_q, freeze_q, skip_q;

  // configuration and grant state
  logic [scs_pkg::NUM_W-1:0]    num_entries_q;
  logic                         grant_active_q, grant_active_d;
  logic [IW-1:0]                holder_q, holder_d;
  logic                         grant_group_q, grant_group_d;

  // scan state
  logic [CW-1:0]                ptr_q, ptr_d;
  logic                         pend_q, pend_d;
  logic                         found_q, found_d;
  logic [IW-1:0]                best_q, best_d;
  scs_pkg::entry_t              best_rec_q, best_rec_d;
  logic [IW-1:0]                addr_q;

  // result
  logic                         res_granted_q, res_granted_d;
  logic                         out_valid_q;
  logic                         out_granted_q, out_group_q, out_busy_q;
  logic [scs_pkg::IDX_W-1:0]    out_index_q;
  logic [scs_pkg::CREDIT_W-1:0] out_wcredit_q;

  // datapath wiring
  logic                         rd_en, wr_en;
  logic [IW-1:0]                rd_addr, wr_addr;
  scs_pkg::entry_t              rec, wr_data;
  scs_pkg::cu_mode_e            cu_mode;
  logic [scs_pkg::CREDIT_W-1:0] cu_operand;
  scs_pkg::cu_res_t             cu_res;

  logic                         in_xfer, out_xfer, done_fire;
  logic                         idx_ok, scan_rd, elig;
  logic [IW-1:0]                idx_addr;
  logic [CW-1:0]                n_act;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_q && !out_stall_i;
  assign done_fire = (state_q == scs_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = state_q != scs_pkg::ST_IDLE;
  assign cfg_ready_o = 1'b1;

  assign idx_ok   = 32'(idx_q) < MAX_ENTRIES;
  assign idx_addr = IW'(idx_q);
  assign n_act    = (32'(num_entries_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(num_entries_q);
  assign scan_rd  = ptr_q < n_act;
  assign elig     = rec.alive && !rec.stunned && !(rec.group && freeze_q);

  scs_entry_mem #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rec),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  scs_credit_unit u_cu (
    .mode_i     (cu_mode),
    .credit_i   (rec.credit),
    .operand_i  (cu_operand),
    .threshold_i(rec.threshold),
    .best_i     (best_rec_q.credit),
    .res_o      (cu_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scs_pkg::ST_IDLE: begin
        if (in_xfer) state_d = scs_pkg::ST_DECODE;
      end
      scs_pkg::ST_DECODE: begin
        priority case (op_q)
          scs_pkg::OP_LOAD, scs_pkg::OP_FLAGS, scs_pkg::OP_DRAIN: begin
            state_d = idx_ok ? scs_pkg::ST_RMW : scs_pkg::ST_DONE;
          end
          scs_pkg::OP_RELEASE: begin
            state_d = grant_active_q ? scs_pkg::ST_RMW : scs_pkg::ST_DONE;
          end
          scs_pkg::OP_TICK: begin
            state_d = grant_active_q ? scs_pkg::ST_DONE : scs_pkg::ST_SCAN;
          end
          default: state_d = scs_pkg::ST_DONE;
        endcase
      end
      scs_pkg::ST_RMW: state_d = scs_pkg::ST_DONE;
      scs_pkg::ST_SCAN: begin
        if (!scan_rd && !pend_q) state_d = found_q ? scs_pkg::ST_WIN : scs_pkg::ST_DONE;
      end
      scs_pkg::ST_WIN: state_d = scs_pkg::ST_DONE;
      scs_pkg::ST_DONE: begin
        if (done_fire) state_d = scs_pkg::ST_IDLE;
      end
      default: state_d = scs_pkg::ST_IDLE;
    endcase
  end

  // Table and credit unit control
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = idx_addr;
    wr_en      = 1'b0;
    wr_addr    = addr_q;
    wr_data    = rec;
    cu_mode    = scs_pkg::CU_ADD_SAT;
    cu_operand = scs_pkg::CREDIT_W'(weight_q);
    unique case (state_q)
      scs_pkg::ST_DECODE: begin
        priority case (op_q)
          scs_pkg::OP_LOAD, scs_pkg::OP_FLAGS, scs_pkg::OP_DRAIN: rd_en = idx_ok;
          scs_pkg::OP_RELEASE: begin
            rd_en   = grant_active_q;
            rd_addr = holder_q;
          end
          default: rd_en = 1'b0;
        endcase
      end
      scs_pkg::ST_RMW: begin
        wr_en = 1'b1;
        priority case (op_q)
          scs_pkg::OP_LOAD: begin
            wr_data.weight    = weight_q;
            wr_data.threshold = threshold_q;
            wr_data.group     = group_q;
          end
          scs_pkg::OP_FLAGS: begin
            wr_data.alive   = alive_q;
            wr_data.stunned = stunned_q;
          end
          scs_pkg::OP_DRAIN: begin
            cu_mode        = scs_pkg::CU_SUB_CLAMP;
            cu_operand     = scs_pkg::CREDIT_W'(drain_q);
            wr_data.credit = cu_res.value;
          end
          default: begin
            // release: zero, or half the threshold on a skip
            cu_mode        = scs_pkg::CU_SET;
            cu_operand     = skip_q ? scs_pkg::CREDIT_W'(rec.threshold / scs_pkg::HALF_DIV) : '0;
            wr_data.credit = cu_res.value;
          end
        endcase
      end
      scs_pkg::ST_SCAN: begin
        rd_en          = scan_rd;
        rd_addr        = IW'(ptr_q);
        // each entry accumulates its own stored weight
        cu_operand     = scs_pkg::CREDIT_W'(rec.weight);
        wr_en          = pend_q && elig;
        wr_data.credit = cu_res.value;
      end
      scs_pkg::ST_WIN: begin
        wr_en          = 1'b1;
        wr_addr        = best_q;
        wr_data        = best_rec_q;
        wr_data.credit = '0;
      end
      default: rd_en = 1'b0;
    endcase
  end

  // Sequencer register updates
  always_comb begin
    grant_active_d = grant_active_q;
    holder_d       = holder_q;
    grant_group_d  = grant_group_q;
    ptr_d          = ptr_q;
    pend_d         = pend_q;
    found_d        = found_q;
    best_d         = best_q;
    best_rec_d     = best_rec_q;
    res_granted_d  = res_granted_q;
    if (in_xfer) res_granted_d = 1'b0;
    unique case (state_q)
      scs_pkg::ST_DECODE: begin
        ptr_d   = '0;
        pend_d  = 1'b0;
        found_d = 1'b0;
        best_d  = '0;
        best_rec_d = '0;
      end
      scs_pkg::ST_RMW: begin
        if (op_q == scs_pkg::OP_RELEASE) grant_active_d = 1'b0;
        if (op_q == scs_pkg::OP_LOAD && grant_active_q && addr_q == holder_q) begin
          grant_group_d = group_q;
        end
      end
      scs_pkg::ST_SCAN: begin
        if (scan_rd) ptr_d = ptr_q + 1'b1;
        pend_d = scan_rd;
        if (pend_q && elig && cu_res.meets && (!found_q || cu_res.beats)) begin
          found_d           = 1'b1;
          best_d            = addr_q;
          best_rec_d        = rec;
          best_rec_d.credit = cu_res.value;
        end
      end
      scs_pkg::ST_WIN: begin
        grant_active_d = 1'b1;
        holder_d       = best_q;
        grant_group_d  = best_rec_q.group;
        res_granted_d  = 1'b1;
      end
      default: ptr_d = ptr_q;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= scs_pkg::ST_IDLE;
      num_entries_q  <= scs_pkg::NUM_ENTRIES_RST;
      grant_active_q <= 1'b0;
      holder_q       <= '0;
      grant_group_q  <= 1'b0;
      ptr_q          <= '0;
      pend_q         <= 1'b0;
      found_q        <= 1'b0;
      res_granted_q  <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      grant_active_q <= grant_active_d;
      holder_q       <= holder_d;
      grant_group_q  <= grant_group_d;
      ptr_q          <= ptr_d;
      pend_q         <= pend_d;
      found_q        <= found_d;
      res_granted_q  <= res_granted_d;
      if (cfg_valid_i && cfg_ready_o) num_entries_q <= cfg_num_entries_i;
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q        <= op_i;
      idx_q       <= entry_index_i;
      weight_q    <= weight_i;
      threshold_q <= threshold_i;
      group_q     <= group_i;
      alive_q     <= alive_i;
      stunned_q   <= stunned_i;
      freeze_q    <= freeze_group1_i;
      skip_q      <= release_skip_i;
      drain_q     <= drain_amount_i;
    end
    if (rd_en) addr_q <= rd_addr;
    best_q     <= best_d;
    best_rec_q <= best_rec_d;
    if (done_fire) begin
      out_granted_q <= res_granted_q;
      out_busy_q    <= grant_active_q;
      out_index_q   <= grant_active_q ? scs_pkg::IDX_W'(holder_q) : '0;
      out_group_q   <= grant_active_q && grant_group_q;
      out_wcredit_q <= res_granted_q ? best_rec_q.credit : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = out_granted_q;
  assign grant_index_o   = out_index_q;
  assign grant_group_o   = out_group_q;
  assign busy_res_o      = out_busy_q;
  assign winner_credit_o = out_wcredit_q;

`ifndef ASSERT_OFF
  // a new grant is always reported with the grant outstanding
  a_grant_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_o |-> busy_res_o)
    else $error("grant reported without busy status");

  // winner credit only accompanies a granting tick
  a_wcredit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> winner_credit_o == '0)
    else $error("winner credit without grant");

  // the scan never walks past the active entry count
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == scs_pkg::ST_SCAN |-> ptr_q <= n_act)
    else $error("scan pointer past active entries");

  // a win step only follows a scan that found a candidate
  a_win_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == scs_pkg::ST_WIN |-> $past(state_q) == scs_pkg::ST_SCAN && found_q)
    else $error("win without candidate");
`endif

endmodule

// ----- bench/credit_threshold_scheduler_tb.sv -----
`timescale 1ns / 1ps

module credit_threshold_scheduler_tb;

  localparam int N_ENT        = scs_pkg::MAX_ENTRIES_DEF;
  localparam int N_PHASES     = 11;
  localparam int PHASE_ITEMS  = 150;
  localparam int SETTLE_CYC   = 32;
  localparam int DIR_ROWS     = 26;

  // opcodes the block does not decode
  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;

  localparam logic [scs_pkg::CREDIT_W-1:0] CREDIT_MAX = '1;

  // entry count per random phase; phase 8 draws one at random
  localparam logic [scs_pkg::NUM_W-1:0] CFG_PLAN [N_PHASES] = '{
    5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd16, 5'd2, 5'd9, 5'd12, 5'd16
  };

  typedef struct packed {
    logic [2:0]                op;
    logic [scs_pkg::IDX_W-1:0] idx;
    logic [scs_pkg::VAL_W-1:0] weight;
    logic [scs_pkg::VAL_W-1:0] thr;
    logic                      grp;
    logic                      alive;
    logic                      stun;
    logic                      frz;
    logic                      skip;
    logic [scs_pkg::VAL_W-1:0] drain;
  } sched_item_t;

  typedef struct packed {
    logic                         granted;
    logic [scs_pkg::IDX_W-1:0]    gidx;
    logic                         ggrp;
    logic                         busy;
    logic [scs_pkg::CREDIT_W-1:0] wcredit;
  } grant_status_t;

  typedef struct packed {
    sched_item_t   item;
    logic          typed;
    grant_status_t status;
  } dir_row_t;

  localparam grant_status_t NO_GRANT  = '0;
  localparam grant_status_t HELD_BY_0 = '{1'b0, 4'd0, 1'b0, 1'b1, 16'd0};

  // directed corners; typed status where it is obvious, else predicted
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // empty table: tick finds no winner
    '{'{scs_pkg::OP_TICK,    4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    '{'{OP_RSVD_A,           4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    // release with nothing granted
    '{'{scs_pkg::OP_RELEASE, 4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0},
      1'b1, NO_GRANT},
    '{'{scs_pkg::OP_LOAD,    4'd0,  8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    '{'{scs_pkg::OP_FLAGS,   4'd0,  8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    // max weight reaches max threshold in one tick
    '{'{scs_pkg::OP_TICK,    4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, '{1'b1, 4'd0, 1'b0, 1'b1, 16'd255}},
    // tick and unknown op while a grant is held
    '{'{scs_pkg::OP_TICK,    4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, HELD_BY_0},
    '{'{OP_RSVD_C,           4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, HELD_BY_0},
    // skip release leaves half the threshold, drains then clamp to zero
    '{'{scs_pkg::OP_RELEASE, 4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0},
      1'b1, NO_GRANT},
    '{'{scs_pkg::OP_DRAIN,   4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd100},
      1'b1, NO_GRANT},
    '{'{scs_pkg::OP_DRAIN,   4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255},
      1'b1, NO_GRANT},
    // top entry: group 1, zero weight, zero threshold
    '{'{scs_pkg::OP_LOAD,    4'd15, 8'd0,   8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    '{'{scs_pkg::OP_FLAGS,   4'd15, 8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    '{'{scs_pkg::OP_FLAGS,   4'd0,  8'd0,   8'd0,   1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    // entry 0 stunned, entry 15 frozen: nobody runs
    '{'{scs_pkg::OP_TICK,    4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    // zero threshold wins with zero credit
    '{'{scs_pkg::OP_TICK,    4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, '{1'b1, 4'd15, 1'b1, 1'b1, 16'd0}},
    '{'{scs_pkg::OP_RELEASE, 4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    '{'{scs_pkg::OP_LOAD,    4'd7,  8'hAA,  8'h55,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    '{'{scs_pkg::OP_FLAGS,   4'd7,  8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    '{'{scs_pkg::OP_FLAGS,   4'd0,  8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b1, NO_GRANT},
    // three contenders from here on
    '{'{scs_pkg::OP_TICK,    4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b0, NO_GRANT},
    '{'{scs_pkg::OP_RELEASE, 4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0},
      1'b0, NO_GRANT},
    '{'{scs_pkg::OP_DRAIN,   4'd7,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd1},
      1'b0, NO_GRANT},
    '{'{scs_pkg::OP_TICK,    4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0},
      1'b0, NO_GRANT},
    '{'{OP_RSVD_B,           4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b0, NO_GRANT},
    '{'{scs_pkg::OP_RELEASE, 4'd0,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
      1'b0, NO_GRANT}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [scs_pkg::NUM_W-1:0] cfg_num_entries_i = '0;

  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [2:0]                op_i = scs_pkg::OP_LOAD;
  logic [scs_pkg::IDX_W-1:0] entry_index_i = '0;
  logic [scs_pkg::VAL_W-1:0] weight_i = '0;
  logic [scs_pkg::VAL_W-1:0] threshold_i = '0;
  logic                      group_i = 1'b0;
  logic                      alive_i = 1'b0;
  logic                      stunned_i = 1'b0;
  logic                      freeze_group1_i = 1'b0;
  logic                      release_skip_i = 1'b0;
  logic [scs_pkg::VAL_W-1:0] drain_amount_i = '0;

  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic                         granted_o;
  logic [scs_pkg::IDX_W-1:0]    grant_index_o;
  logic                         grant_group_o;
  logic                         busy_res_o;
  logic [scs_pkg::CREDIT_W-1:0] winner_credit_o;

  credit_threshold_scheduler dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_num_entries_i (cfg_num_entries_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .entry_index_i     (entry_index_i),
    .weight_i          (weight_i),
    .threshold_i       (threshold_i),
    .group_i           (group_i),
    .alive_i           (alive_i),
    .stunned_i         (stunned_i),
    .freeze_group1_i   (freeze_group1_i),
    .release_skip_i    (release_skip_i),
    .drain_amount_i    (drain_amount_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_o         (granted_o),
    .grant_index_o     (grant_index_o),
    .grant_group_o     (grant_group_o),
    .busy_res_o        (busy_res_o),
    .winner_credit_o   (winner_credit_o)
  );

  // shadow of the scheduler table and grant
  logic [scs_pkg::CREDIT_W-1:0] sh_credit [N_ENT];
  logic [scs_pkg::VAL_W-1:0]    sh_weight [N_ENT];
  logic [scs_pkg::VAL_W-1:0]    sh_thr    [N_ENT];
  logic                         sh_group  [N_ENT];
  logic                         sh_alive  [N_ENT];
  logic                         sh_stun   [N_ENT];
  logic                         sh_busy = 1'b0;
  logic [scs_pkg::IDX_W-1:0]    sh_holder = '0;
  logic [scs_pkg::NUM_W-1:0]    sh_num = scs_pkg::NUM_ENTRIES_RST;

  grant_status_t status_q [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int grants_seen = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < N_ENT; i++) begin
      sh_credit[i] = '0;
      sh_weight[i] = '0;
      sh_thr[i]    = '0;
      sh_group[i]  = 1'b0;
      sh_alive[i]  = 1'b0;
      sh_stun[i]   = 1'b0;
    end
  end

  function automatic bit may_run(int i, logic frz);
    return sh_alive[i] && !sh_stun[i] && !(sh_group[i] && frz);
  endfunction

  function automatic int entries_in_play();
    return (int'(sh_num) > N_ENT) ? N_ENT : int'(sh_num);
  endfunction

  // Apply one item to the shadow table and return the status it reports
  function automatic grant_status_t predict_status(sched_item_t it);
    grant_status_t st;
    int n;
    int best;
    bit found;
    logic [scs_pkg::CREDIT_W:0] sum;
    logic [scs_pkg::CREDIT_W-1:0] best_credit;
    st = '0;
    n = entries_in_play();
    found = 1'b0;
    best = 0;
    best_credit = '0;
    case (it.op)
      scs_pkg::OP_LOAD: if (int'(it.idx) < N_ENT) begin
        sh_weight[it.idx] = it.weight;
        sh_thr[it.idx]    = it.thr;
        sh_group[it.idx]  = it.grp;
      end
      scs_pkg::OP_FLAGS: if (int'(it.idx) < N_ENT) begin
        sh_alive[it.idx] = it.alive;
        sh_stun[it.idx]  = it.stun;
      end
      scs_pkg::OP_TICK: if (!sh_busy) begin
        // accumulate; carry out of the credit width saturates
        for (int i = 0; i < n; i++) begin
          if (may_run(i, it.frz)) begin
            sum = {1'b0, sh_credit[i]} + sh_weight[i];
            sh_credit[i] = sum[scs_pkg::CREDIT_W] ? CREDIT_MAX :
                           sum[scs_pkg::CREDIT_W-1:0];
          end
        end
        // strict compare keeps ties on the lowest index
        for (int i = 0; i < n; i++) begin
          if (may_run(i, it.frz) && sh_credit[i] >= sh_thr[i] &&
              (!found || sh_credit[i] > best_credit)) begin
            found = 1'b1;
            best = i;
            best_credit = sh_credit[i];
          end
        end
        if (found) begin
          sh_busy = 1'b1;
          sh_holder = scs_pkg::IDX_W'(best);
          sh_credit[best] = '0;
          st.granted = 1'b1;
          st.wcredit = best_credit;
        end
      end
      scs_pkg::OP_RELEASE: if (sh_busy) begin
        sh_credit[sh_holder] = it.skip ?
          scs_pkg::CREDIT_W'(sh_thr[sh_holder] / scs_pkg::HALF_DIV) : '0;
        sh_busy = 1'b0;
      end
      scs_pkg::OP_DRAIN: if (int'(it.idx) < N_ENT) begin
        sh_credit[it.idx] = (sh_credit[it.idx] > it.drain) ?
                            sh_credit[it.idx] - it.drain : '0;
      end
      default: ;
    endcase
    if (sh_busy) begin
      st.gidx = sh_holder;
      st.ggrp = sh_group[sh_holder];
      st.busy = 1'b1;
    end
    return st;
  endfunction

  // Random item, biased toward grant/release cycles on live entries
  function automatic sched_item_t random_item();
    sched_item_t it;
    int roll;
    int n;
    n = entries_in_play();
    roll = $urandom_range(0, 99);
    it.weight = scs_pkg::VAL_W'($urandom_range(0, 255));
    it.thr    = ($urandom_range(0, 7) == 0) ? '0 : scs_pkg::VAL_W'($urandom_range(0, 255));
    it.grp    = 1'($urandom_range(0, 1));
    it.alive  = ($urandom_range(0, 99) < 85);
    it.stun   = ($urandom_range(0, 99) < 15);
    it.frz    = ($urandom_range(0, 99) < 25);
    it.skip   = 1'($urandom_range(0, 1));
    it.drain  = scs_pkg::VAL_W'($urandom_range(0, 255));
    it.idx    = (n > 0 && $urandom_range(0, 3) != 0) ?
                scs_pkg::IDX_W'($urandom_range(0, n - 1)) :
                scs_pkg::IDX_W'($urandom_range(0, N_ENT - 1));
    if (sh_busy && roll < 45) it.op = scs_pkg::OP_RELEASE;
    else if (roll < 60) it.op = scs_pkg::OP_TICK;
    else if (roll < 72) it.op = scs_pkg::OP_LOAD;
    else if (roll < 84) it.op = scs_pkg::OP_FLAGS;
    else if (roll < 90) it.op = scs_pkg::OP_RELEASE;
    else if (roll < 97) it.op = scs_pkg::OP_DRAIN;
    else it.op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
    return it;
  endfunction

  // Present one item, hold it until transfer, then log its expected status
  task automatic send_item(input sched_item_t it, input logic typed,
                           input grant_status_t typed_status);
    grant_status_t want;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid_i      <= 1'b1;
    op_i            <= it.op;
    entry_index_i   <= it.idx;
    weight_i        <= it.weight;
    threshold_i     <= it.thr;
    group_i         <= it.grp;
    alive_i         <= it.alive;
    stunned_i       <= it.stun;
    freeze_group1_i <= it.frz;
    release_skip_i  <= it.skip;
    drain_amount_i  <= it.drain;
    do @(posedge clk_i); while (in_stall_o);
    want = predict_status(it);
    status_q.push_back(typed ? typed_status : want);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding status plus pipeline slack
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_num_entries(input logic [scs_pkg::NUM_W-1:0] val);
    cfg_num_entries_i <= val;
    cfg_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sh_num = val;
  endtask

  // Result side backpressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    grant_status_t got;
    grant_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{granted_o, grant_index_o, grant_group_o, busy_res_o, winner_credit_o};
      if (status_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, got);
        errors++;
      end else begin
        want = status_q.pop_front();
        results_checked++;
        if (got.granted) grants_seen++;
        if (got.granted !== want.granted) begin
          $display("%0t: granted exp %0d act %0d", $time, want.granted, got.granted);
          errors++;
        end
        if (got.gidx !== want.gidx) begin
          $display("%0t: grant_index exp %0d act %0d", $time, want.gidx, got.gidx);
          errors++;
        end
        if (got.ggrp !== want.ggrp) begin
          $display("%0t: grant_group exp %0d act %0d", $time, want.ggrp, got.ggrp);
          errors++;
        end
        if (got.busy !== want.busy) begin
          $display("%0t: busy_res exp %0d act %0d", $time, want.busy, got.busy);
          errors++;
        end
        if (got.wcredit !== want.wcredit) begin
          $display("%0t: winner_credit exp %0d act %0d", $time, want.wcredit,
                   got.wcredit);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed corners, then random phases
  initial begin
    sched_item_t it;
    logic [scs_pkg::NUM_W-1:0] nval;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 9;
    rx_idle_pct = 68;
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].status);
    end
    wait_quiet();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // dense sender / stalling receiver, then swapped, then full rate
      if (ph < 4) begin
        tx_idle_pct = 9;
        rx_idle_pct = 68;
      end else if (ph < 8) begin
        tx_idle_pct = 68;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      nval = (ph == 8) ? scs_pkg::NUM_W'($urandom_range(0, 31)) : CFG_PLAN[ph];
      write_num_entries(nval);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        it = random_item();
        send_item(it, 1'b0, NO_GRANT);
      end
      wait_quiet();
    end

    $display("Sent %0d items over %0d entry-count settings; %0d statuses checked,",
             items_sent, N_PHASES + 1, results_checked);
    $display("%0d of them new grants, errors: %0d", grants_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6ms;
    $display("Timeout: %0d statuses still outstanding", status_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
